// ===== rtl/swmc_pkg.sv =====
// package for the sliding window median cost block
// widths, limits and shared controller/datapath command and status types
package swmc_pkg;

  localparam int SampleW   = 32;
  localparam int CostW     = 40;
  localparam int SizeW     = 9;
  localparam int WindowMax = 256;

  // controller to datapath commands
  typedef struct packed {
    logic clear;      // config write: clear fill count and ring pointer
    logic start;      // latch sample and set up a new walk
    logic rd_ring;    // read oldest sample from ring
    logic walk;       // one step of remove/insert walk
    logic med_rd;     // read median entry
    logic sum_step;   // one step of the cost sum
    logic finish;     // update counters after the walk
  } swmc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;       // window already full at start of item
    logic walk_done;  // insert/remove walk finished
    logic sum_done;   // cost sum finished
    logic will_fill;  // window full after this item
  } swmc_sts_t;

endpackage

// ===== rtl/sliding_window_median_cost_core.sv =====
// sliding window median cost core: one sample per transaction
// full window: each sample runs one sorted-store walk for remove/insert and one
// for the cost sum before cost_valid; a sample that leaves the window short of full
// runs only the walk and gives no cost; a new sample is taken only once the last is done
// a waiting cost does not block input; the next sum holds until that cost is taken
// rst is synchronous active high: clears counters and handshake; window_size is 1
module sliding_window_median_cost_core #(
  parameter int WINDOW_MAX = swmc_pkg::WindowMax
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swmc_pkg::SizeW-1:0]          cfg_wdata,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [swmc_pkg::SampleW-1:0] sample,
  output logic                                cost_valid,
  input  logic                                cost_stall,
  output logic [swmc_pkg::CostW-1:0]          cost
);
  import swmc_pkg::*;

  logic [SizeW-1:0] window_size;
  swmc_cmd_t cmd;
  swmc_sts_t sts;

  // window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= SizeW'(1);
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  swmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .sample_valid(sample_valid),
    .sample_stall(sample_stall), .cfg_we(cfg_we), .cost_valid(cost_valid),
    .cost_stall(cost_stall), .sts(sts), .cmd(cmd)
  );

  swmc_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk(clk), .rst(rst), .window_size(window_size), .sample(sample),
    .cmd(cmd), .sts(sts), .cost(cost)
  );
endmodule

// ===== rtl/swmc_ctrl.sv =====
// controller state machine for the sliding window median cost block
// depends on swmc_pkg; sequences the datapath through one item at a time
module swmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic                cfg_we,
  output logic                cost_valid,
  input  logic                cost_stall,
  input  swmc_pkg::swmc_sts_t sts,
  output swmc_pkg::swmc_cmd_t cmd
);
  import swmc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RING = 7'b0000010,
    S_WALK = 7'b0000100,
    S_MED  = 7'b0001000,
    S_MEDW = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   busy_out;

  // output register holds a finished cost until taken
  // a waiting cost does not block input, only the next cost sum
  assign cost_valid   = busy_out;
  assign sample_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.clear  = cfg_we;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_valid && !sample_stall) begin
          cmd.start  = 1'b1;
          state_next = S_RING;
        end
      end
      S_RING: begin
        cmd.rd_ring = 1'b1;
        state_next  = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_next = S_MED;
        end
      end
      S_MED: begin
        // hold while the previous cost still waits and the sum would reuse it
        if (sts.will_fill && busy_out && cost_stall) begin
          state_next = S_MED;
        end else begin
          cmd.finish = 1'b1;
          if (sts.will_fill) begin
            cmd.med_rd = 1'b1;
            state_next = S_MEDW;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_MEDW: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      busy_out <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT) begin
        busy_out <= 1'b1;
      end else if (!cost_stall) begin
        busy_out <= 1'b0;
      end
    end
  end

  // a new cost never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !busy_out) else $error("cost overwritten");
  // start only from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == S_IDLE) else $error("start outside idle");
  // result raised only after sum
  a_out_after_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(busy_out) |-> $past(state) == S_OUT) else $error("stray result");
endmodule

// ===== rtl/swmc_dp.sv =====
// datapath for the sliding window median cost block
// depends on swmc_pkg; holds ring and sorted memories, walk and sum logic
module swmc_dp #(
  parameter int WINDOW_MAX = swmc_pkg::WindowMax
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [swmc_pkg::SizeW-1:0]        window_size,
  input  logic signed [swmc_pkg::SampleW-1:0] sample,
  input  swmc_pkg::swmc_cmd_t               cmd,
  output swmc_pkg::swmc_sts_t               sts,
  output logic [swmc_pkg::CostW-1:0]        cost
);
  import swmc_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic signed [SampleW-1:0] ring [WINDOW_MAX];
  logic signed [SampleW-1:0] srt  [WINDOW_MAX];

  logic [CW-1:0] fill, size, rd_idx, wr_idx, n;
  logic [AW-1:0] oldest;
  logic signed [SampleW-1:0] s_reg, old_reg, rd_data, med;
  logic full_reg, removed, placed, rd_ok;
  logic [CostW-1:0] acc;

  // effective size: zero reads as one, large values saturate
  always_comb begin
    if (window_size == '0) begin
      size = CW'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      size = CW'(WINDOW_MAX);
    end else begin
      size = CW'(window_size);
    end
  end

  assign sts.full      = full_reg;
  assign sts.will_fill = full_reg || (fill + CW'(1) >= size);
  assign sts.walk_done = rd_ok && (rd_idx >= n);
  assign sts.sum_done  = rd_ok && (rd_idx >= size);
  assign cost          = acc;

  // walk compares one entry per cycle through a registered read port;
  // the new sorted order is written in place behind the read index
  logic pend;
  logic signed [SampleW-1:0] pend_val;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill   <= '0;
      oldest <= '0;
    end else if (cmd.finish) begin
      if (!full_reg) begin
        fill <= fill + CW'(1);
      end else if (32'(oldest) + 1 >= 32'(size)) begin
        oldest <= '0;
      end else begin
        oldest <= oldest + AW'(1);
      end
    end
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.walk || cmd.sum_step || cmd.rd_ring;
    end
  end

  // walk state: single bottom-up pass, write index lags read index
  // entries equal to old are skipped once; s placed before first larger
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      s_reg    <= sample;
      full_reg <= (fill >= size);
      if (fill >= size) begin
        n <= size;
      end else begin
        n <= fill;
      end
      rd_idx  <= '0;
      wr_idx  <= '0;
      removed <= !(fill >= size);
      placed  <= 1'b0;
      pend    <= 1'b0;
      if (fill < size) begin
        ring[fill[AW-1:0]] <= sample;
      end
    end
    if (cmd.rd_ring) begin
      old_reg <= ring[oldest];
      if (full_reg) begin
        ring[oldest] <= s_reg;
      end
    end
    if (cmd.walk) begin
      if (rd_ok && rd_idx < n) begin
        rd_idx <= rd_idx + CW'(1);
        if (!removed && rd_data == old_reg) begin
          removed <= 1'b1;
        end else if (!placed && rd_data > s_reg) begin
          srt[wr_idx[AW-1:0]] <= s_reg;
          placed   <= 1'b1;
          wr_idx   <= wr_idx + CW'(1);
          pend     <= 1'b1;
          pend_val <= rd_data;
        end else if (pend) begin
          srt[wr_idx[AW-1:0]] <= pend_val;
          pend_val <= rd_data;
          wr_idx   <= wr_idx + CW'(1);
        end else begin
          srt[wr_idx[AW-1:0]] <= rd_data;
          wr_idx <= wr_idx + CW'(1);
        end
      end else if (rd_ok) begin
        if (pend) begin
          srt[wr_idx[AW-1:0]] <= pend_val;
        end else if (!placed) begin
          srt[wr_idx[AW-1:0]] <= s_reg;
        end
      end
    end
    if (cmd.med_rd) begin
      rd_idx <= '0;
      acc    <= '0;
      med    <= srt[AW'((size - CW'(1)) >> 1)];
    end
    if (cmd.sum_step && rd_ok && rd_idx < size) begin
      rd_idx <= rd_idx + CW'(1);
      if (rd_data >= med) begin
        acc <= acc + CostW'(33'(rd_data) - 33'(med));
      end else begin
        acc <= acc + CostW'(33'(med) - 33'(rd_data));
      end
    end
  end

  // registered read port of the sorted memory, address runs ahead
  logic [CW-1:0] ra;
  always_comb begin
    ra = rd_idx;
    if (rd_ok && (cmd.walk || cmd.sum_step)) begin
      ra = rd_idx + CW'(1);
    end
  end
  always_ff @(posedge clk) begin
    rd_data <= srt[ra[AW-1:0]];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= size || cmd.clear || $changed(window_size))
    else $error("fill past size");
  a_wr_lag: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> wr_idx <= rd_idx + CW'(1)) else $error("write ahead of read");
  a_sum_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_step |-> rd_idx <= size) else $error("sum overrun");
endmodule
